FILE: rtl/dth_pkg.sv
// Shared types and constants for the deadline timer heap.
// No dependencies; imported by dth_dp, dth_ctrl and the top unit (dth_ram does not use it).
package dth_pkg;

  localparam int MAX_TIMERS  = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W = $clog2(MAX_TIMERS);
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_ARM_PER = 2'd1,
    FN_ARM_ONE = 2'd2,
    FN_CANCEL  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FIRED    = 3'd3,
    ST_NONE     = 3'd4
  } stat_e;

  typedef struct packed {
    logic [31:0] dl;
    logic [23:0] per;
    logic [31:0] id;
    logic        single;
  } entry_t;

  // datapath commands, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INS_INIT,
    OP_INS_PER,
    OP_RD_PARENT,
    OP_UP_MOVE,
    OP_RD_L,
    OP_TAKE_L,
    OP_TAKE_R,
    OP_DN_MOVE,
    OP_WR_E,
    OP_RD_LAST,
    OP_REM_TAKE,
    OP_SCAN_INIT,
    OP_RD_I,
    OP_INC_I,
    OP_TICK_INIT,
    OP_RD_ROOT,
    OP_FIRE,
    OP_PEND,
    OP_EMIT_OK,
    OP_EMIT_FULL,
    OP_EMIT_NF,
    OP_EMIT_NONE,
    OP_EMIT_MID,
    OP_EMIT_LAST
  } dp_op_e;

  typedef struct packed {
    func_e func;
    logic  full;
    logic  cnt_zero;
    logic  i_zero;
    logic  l_in;
    logic  r_in;
    logic  i_lt_cnt;
    logic  e_lt_rd;
    logic  a_lt_e;
    logic  due;
    logic  match;
    logic  res_full;
    logic  pend_v;
    logic  f_single;
    logic  moved;
    logic  out_free;
  } dp_st_t;

endpackage

FILE: rtl/dth_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/dth_dp.sv
// Datapath: heap RAM, count and clock registers, sift registers, result stage.
// Depends on dth_pkg and dth_ram.
module dth_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        func_i,
  input  logic [23:0]       delay_ms_i,
  input  logic [31:0]       timer_id_i,
  input  dth_pkg::dp_op_e   cmd_i,
  output dth_pkg::dp_st_t   st_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [31:0]       fired_id_o,
  output logic [31:0]       fire_time_o,
  output logic [5:0]        active_count_o,
  output logic              last_o
);
  import dth_pkg::*;

  func_e              fn_q;
  logic [23:0]        dly_q;
  logic [31:0]        tid_q;
  logic [CNT_W-1:0]   cnt_q, i_q, pick_q;
  logic [31:0]        clk_q;
  logic               moved_q;
  entry_t             e_q, a_q, f_q, rd;
  logic [RES_W-1:0]   n_q;
  logic               pv_q;
  logic [31:0]        pid_q;
  logic [CNT_W-1:0]   pcnt_q;
  logic               ov_q, olast_q;
  stat_e              os_q;
  logic [31:0]        oid_q, otime_q;
  logic [CNT_W-1:0]   ocnt_q;

  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr;
  entry_t             wdata;
  logic [CNT_W:0]     l_ix, r_ix, cnt_x, par_ix, last_ix;
  logic               out_free;
  logic [23:0]        per_cl;
  logic [CNT_W+5:0]   ocnt_x;

  logic [$bits(entry_t)-1:0] rdata_raw;

  assign rd      = entry_t'(rdata_raw);
  assign cnt_x   = {1'b0, cnt_q};
  assign l_ix    = {i_q, 1'b0} + (CNT_W+1)'(1);
  assign r_ix    = {i_q, 1'b0} + (CNT_W+1)'(2);
  assign par_ix  = ({1'b0, i_q} - (CNT_W+1)'(1)) >> 1;
  assign last_ix = cnt_x - (CNT_W+1)'(1);
  assign out_free = !ov_q || out_ready_i;
  assign per_cl  = (f_q.per == 24'd0) ? 24'd1 : f_q.per;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = i_q[IDX_W-1:0];
    wdata = e_q;
    raddr = i_q[IDX_W-1:0];
    unique case (cmd_i)
      OP_RD_PARENT: begin re = 1'b1; raddr = par_ix[IDX_W-1:0]; end
      OP_UP_MOVE:   begin we = 1'b1; wdata = rd; end
      OP_RD_L:      begin re = 1'b1; raddr = l_ix[IDX_W-1:0]; end
      OP_TAKE_L:    begin re = 1'b1; raddr = r_ix[IDX_W-1:0]; end
      OP_DN_MOVE:   begin we = 1'b1; wdata = a_q; end
      OP_WR_E:      we = 1'b1;
      OP_RD_LAST:   begin re = 1'b1; raddr = last_ix[IDX_W-1:0]; end
      OP_RD_I:      re = 1'b1;
      OP_RD_ROOT:   begin re = 1'b1; raddr = '0; end
      default: ;
    endcase
  end

  dth_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_TIMERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_i) begin
      fn_q  <= func_e'(func_i);
      dly_q <= delay_ms_i;
      tid_q <= timer_id_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      clk_q   <= '0;
      i_q     <= '0;
      pick_q  <= '0;
      moved_q <= 1'b0;
      n_q     <= '0;
      pv_q    <= 1'b0;
    end else begin
      unique case (cmd_i)
        OP_INS_INIT: begin
          e_q     <= '{dl: clk_q + {8'd0, dly_q}, per: dly_q, id: tid_q,
                       single: (fn_q == FN_ARM_ONE)};
          i_q     <= cnt_q;
          cnt_q   <= cnt_q + CNT_W'(1);
          moved_q <= 1'b0;
        end
        OP_INS_PER: begin
          e_q     <= '{dl: clk_q + {8'd0, per_cl}, per: f_q.per, id: f_q.id,
                       single: 1'b0};
          i_q     <= cnt_q;
          cnt_q   <= cnt_q + CNT_W'(1);
          moved_q <= 1'b0;
        end
        OP_UP_MOVE: begin
          i_q     <= par_ix[CNT_W-1:0];
          moved_q <= 1'b1;
        end
        OP_TAKE_L: begin
          a_q    <= rd;
          pick_q <= l_ix[CNT_W-1:0];
        end
        OP_TAKE_R: begin
          if (!(a_q.dl < rd.dl)) begin
            a_q    <= rd;
            pick_q <= r_ix[CNT_W-1:0];
          end
        end
        OP_DN_MOVE: i_q <= pick_q;
        OP_REM_TAKE: begin
          e_q     <= rd;
          cnt_q   <= cnt_q - CNT_W'(1);
          moved_q <= 1'b0;
        end
        OP_SCAN_INIT: i_q <= '0;
        OP_INC_I:     i_q <= i_q + CNT_W'(1);
        OP_TICK_INIT: begin
          clk_q <= clk_q + 32'd1;
          n_q   <= '0;
          pv_q  <= 1'b0;
        end
        OP_FIRE: begin
          f_q <= rd;
          i_q <= '0;
        end
        OP_PEND: begin
          pv_q   <= 1'b1;
          pid_q  <= f_q.id;
          pcnt_q <= cnt_q;
          n_q    <= n_q + RES_W'(1);
        end
        OP_EMIT_MID, OP_EMIT_LAST: pv_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      unique case (cmd_i)
        OP_EMIT_OK, OP_EMIT_FULL, OP_EMIT_NF, OP_EMIT_NONE: begin
          ov_q    <= 1'b1;
          oid_q   <= '0;
          otime_q <= clk_q;
          ocnt_q  <= cnt_q;
          olast_q <= 1'b1;
          unique case (cmd_i)
            OP_EMIT_OK:   os_q <= ST_OK;
            OP_EMIT_FULL: os_q <= ST_FULL;
            OP_EMIT_NF:   os_q <= ST_NOTFOUND;
            default:      os_q <= ST_NONE;
          endcase
        end
        OP_EMIT_MID, OP_EMIT_LAST: begin
          ov_q    <= 1'b1;
          os_q    <= ST_FIRED;
          oid_q   <= pid_q;
          otime_q <= clk_q;
          ocnt_q  <= pcnt_q;
          olast_q <= (cmd_i == OP_EMIT_LAST);
        end
        default: begin
          if (out_ready_i) begin
            ov_q <= 1'b0;
          end
        end
      endcase
    end
  end

  assign ocnt_x         = {6'd0, ocnt_q};
  assign out_valid_o    = ov_q;
  assign status_o       = os_q;
  assign fired_id_o     = oid_q;
  assign fire_time_o    = otime_q;
  assign active_count_o = ocnt_x[5:0];
  assign last_o         = olast_q;

  always_comb begin
    st_o.func     = fn_q;
    st_o.full     = (cnt_q == CNT_W'(MAX_TIMERS));
    st_o.cnt_zero = (cnt_q == '0);
    st_o.i_zero   = (i_q == '0);
    st_o.l_in     = (l_ix < cnt_x);
    st_o.r_in     = (r_ix < cnt_x);
    st_o.i_lt_cnt = (i_q < cnt_q);
    st_o.e_lt_rd  = (e_q.dl < rd.dl);
    st_o.a_lt_e   = (a_q.dl < e_q.dl);
    st_o.due      = (rd.dl <= clk_q);
    st_o.match    = (rd.id == tid_q);
    st_o.res_full = (n_q == RES_W'(MAX_RESULTS));
    st_o.pend_v   = pv_q;
    st_o.f_single = f_q.single;
    st_o.moved    = moved_q;
    st_o.out_free = out_free;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TIMERS))
    else $error("armed count above capacity");
  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (i_q < cnt_q))
    else $error("heap write outside armed slots");
  a_last_nonfire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && os_q != ST_FIRED) |-> olast_q)
    else $error("non-fire result not marked last");
endmodule

FILE: rtl/dth_ctrl.sv
// Sequencer for arm, cancel and tick items; issues one datapath command a cycle.
// Depends on dth_pkg.
module dth_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  dth_pkg::dp_st_t st_i,
  output dth_pkg::dp_op_e cmd_o,
  output logic            idle_o
);
  import dth_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_UP_TOP, S_UP_CHK,
    S_DN_TOP, S_DN_L, S_DN_R, S_DN_CMP,
    S_WR_E, S_DONE,
    S_RM_RD, S_RM_TAKE, S_RM_CHK,
    S_SC_RD, S_SC_CHK,
    S_TK_CHK, S_TK_DUE, S_TK_FLUSH, S_TK_FIRE, S_TK_INS, S_TK_PEND, S_TK_END,
    S_E_OK, S_E_FULL, S_E_NF
  } state_e;

  typedef enum logic [1:0] {
    J_ARM, J_CANCEL, J_TICK_REM, J_TICK_INS
  } job_e;

  state_e state_q, state_d, stop_to;
  job_e   job_q, job_d;
  logic   idle_q;

  // where a sift-up ends: inserts and moved entries are written, else sift down
  assign stop_to = (st_i.moved || job_q == J_ARM || job_q == J_TICK_INS)
                   ? S_WR_E : S_DN_TOP;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    cmd_o   = OP_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i && idle_q) state_d = S_DISP;
      S_DISP: begin
        unique case (st_i.func)
          FN_TICK: begin cmd_o = OP_TICK_INIT; state_d = S_TK_CHK; end
          FN_CANCEL: begin cmd_o = OP_SCAN_INIT; state_d = S_SC_RD; end
          default: begin
            if (st_i.full) begin
              state_d = S_E_FULL;
            end else begin
              cmd_o = OP_INS_INIT; job_d = J_ARM; state_d = S_UP_TOP;
            end
          end
        endcase
      end
      S_UP_TOP: begin
        if (st_i.i_zero) state_d = stop_to;
        else begin cmd_o = OP_RD_PARENT; state_d = S_UP_CHK; end
      end
      S_UP_CHK: begin
        if (st_i.e_lt_rd) begin cmd_o = OP_UP_MOVE; state_d = S_UP_TOP; end
        else state_d = stop_to;
      end
      S_DN_TOP: begin
        if (st_i.l_in) begin cmd_o = OP_RD_L; state_d = S_DN_L; end
        else state_d = S_WR_E;
      end
      S_DN_L: begin
        cmd_o = OP_TAKE_L;
        state_d = st_i.r_in ? S_DN_R : S_DN_CMP;
      end
      S_DN_R: begin cmd_o = OP_TAKE_R; state_d = S_DN_CMP; end
      S_DN_CMP: begin
        if (st_i.a_lt_e) begin cmd_o = OP_DN_MOVE; state_d = S_DN_TOP; end
        else state_d = S_WR_E;
      end
      S_WR_E: begin cmd_o = OP_WR_E; state_d = S_DONE; end
      S_DONE: begin
        unique case (job_q)
          J_ARM, J_CANCEL: state_d = S_E_OK;
          J_TICK_REM:      state_d = st_i.f_single ? S_TK_PEND : S_TK_INS;
          J_TICK_INS:      state_d = S_TK_PEND;
        endcase
      end
      S_RM_RD:   begin cmd_o = OP_RD_LAST; state_d = S_RM_TAKE; end
      S_RM_TAKE: begin cmd_o = OP_REM_TAKE; state_d = S_RM_CHK; end
      S_RM_CHK:  state_d = st_i.i_lt_cnt ? S_UP_TOP : S_DONE;
      S_SC_RD: begin
        if (st_i.i_lt_cnt) begin cmd_o = OP_RD_I; state_d = S_SC_CHK; end
        else state_d = S_E_NF;
      end
      S_SC_CHK: begin
        if (st_i.match) begin job_d = J_CANCEL; state_d = S_RM_RD; end
        else begin cmd_o = OP_INC_I; state_d = S_SC_RD; end
      end
      S_TK_CHK: begin
        if (st_i.cnt_zero || st_i.res_full) state_d = S_TK_END;
        else begin cmd_o = OP_RD_ROOT; state_d = S_TK_DUE; end
      end
      S_TK_DUE: begin
        if (!st_i.due) state_d = S_TK_END;
        else state_d = st_i.pend_v ? S_TK_FLUSH : S_TK_FIRE;
      end
      S_TK_FLUSH: begin
        if (st_i.out_free) begin cmd_o = OP_EMIT_MID; state_d = S_TK_FIRE; end
      end
      S_TK_FIRE: begin
        cmd_o = OP_FIRE; job_d = J_TICK_REM; state_d = S_RM_RD;
      end
      S_TK_INS: begin
        cmd_o = OP_INS_PER; job_d = J_TICK_INS; state_d = S_UP_TOP;
      end
      S_TK_PEND: begin cmd_o = OP_PEND; state_d = S_TK_CHK; end
      S_TK_END: begin
        if (st_i.out_free) begin
          cmd_o = st_i.pend_v ? OP_EMIT_LAST : OP_EMIT_NONE;
          state_d = S_IDLE;
        end
      end
      S_E_OK:   if (st_i.out_free) begin cmd_o = OP_EMIT_OK; state_d = S_IDLE; end
      S_E_FULL: if (st_i.out_free) begin cmd_o = OP_EMIT_FULL; state_d = S_IDLE; end
      S_E_NF:   if (st_i.out_free) begin cmd_o = OP_EMIT_NF; state_d = S_IDLE; end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= J_ARM;
      idle_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      idle_q  <= (state_d == S_IDLE) && !(state_q == S_IDLE && in_valid_i && idle_q);
    end
  end

  assign idle_o = idle_q;

  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> state_q == S_IDLE)
    else $error("ready raised outside idle");
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_q && in_valid_i) |=> (state_q == S_DISP && !idle_q))
    else $error("accepted beat not dispatched");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == OP_EMIT_OK || cmd_o == OP_EMIT_LAST || cmd_o == OP_EMIT_MID)
      |-> st_i.out_free)
    else $error("result emitted over a held beat");
endmodule

FILE: rtl/deadline_timer_heap_unit.sv
// Deadline timer heap: binary min-heap of timers in one RAM.
// Arm sifts the new timer up; cancel scans the slots in order and then removes
// the match; tick advances the ms clock and fires each due timer from the root.
// One item at a time: in_ready_o stays low until the item's last result is issued.
// Reset: asynchronous active low; clears armed count and clock, heap RAM is not cleared.
// Depends on dth_pkg, dth_ctrl, dth_dp, dth_ram.
module deadline_timer_heap_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [23:0] delay_ms_i,
  input  logic [31:0] timer_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] fired_id_o,
  output logic [31:0] fire_time_o,
  output logic [5:0]  active_count_o,
  output logic        last_o
);
  import dth_pkg::*;

  dp_op_e cmd;
  dp_st_t st;
  logic   idle;

  // The controller walks sifts, scans and tick firing; the datapath holds the
  // heap, the count and the ms clock. A fired result is held back one step so
  // its last flag is known before the beat goes out.
  dth_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .st_i      (st),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  dth_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (idle),
    .func_i        (func_i),
    .delay_ms_i    (delay_ms_i),
    .timer_id_i    (timer_id_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .fired_id_o    (fired_id_o),
    .fire_time_o   (fire_time_o),
    .active_count_o(active_count_o),
    .last_o        (last_o)
  );

  assign in_ready_o = idle;
endmodule

FILE: sim/tb.sv
// Testbench for deadline_timer_heap_unit: directed table, a fill-to-full run, then random items,
// checked beat by beat against a behavioral heap model. Depends on dth_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import dth_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int N_RANDOM = 420;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  func_i;
  logic [23:0] delay_ms_i;
  logic [31:0] timer_id_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] fired_id_o, fire_time_o;
  logic [5:0]  active_count_o;
  logic        last_o;

  deadline_timer_heap_unit dut (.*);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] fired_id;
    logic [31:0] fire_time;
    logic [5:0]  active_count;
    logic        last;
  } beat_t;

  // model state
  logic [31:0] m_dl [MAX_TIMERS];
  logic [23:0] m_per [MAX_TIMERS];
  logic [31:0] m_id [MAX_TIMERS];
  logic        m_single [MAX_TIMERS];
  int          m_cnt;
  logic [31:0] m_clock;

  beat_t pending_beats[$];
  int    errors = 0;
  int    mism = 0;
  bit    idle_off = 0;
  int    cycles = 0;

  function automatic void heap_swap(int a, int b);
    logic [31:0] d, i; logic [23:0] p; logic s;
    d = m_dl[a]; p = m_per[a]; i = m_id[a]; s = m_single[a];
    m_dl[a] = m_dl[b]; m_per[a] = m_per[b]; m_id[a] = m_id[b]; m_single[a] = m_single[b];
    m_dl[b] = d; m_per[b] = p; m_id[b] = i; m_single[b] = s;
  endfunction

  function automatic void heap_up(int i);
    int up;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (m_dl[i] < m_dl[up]) begin
        heap_swap(i, up);
        i = up;
      end else break;
    end
  endfunction

  function automatic void heap_down(int i);
    int l, r, pick;
    while (i < m_cnt) begin
      l = 2 * i + 1; r = 2 * i + 2;
      if (l >= m_cnt) break;
      pick = l;
      if (r < m_cnt && !(m_dl[l] < m_dl[r])) pick = r;
      if (m_dl[pick] < m_dl[i]) begin
        heap_swap(i, pick);
        i = pick;
      end else break;
    end
  endfunction

  function automatic void heap_insert(logic [31:0] dly, logic [31:0] id, logic s);
    m_dl[m_cnt] = m_clock + dly;
    m_per[m_cnt] = dly[23:0];
    m_id[m_cnt] = id;
    m_single[m_cnt] = s;
    m_cnt++;
    heap_up(m_cnt - 1);
  endfunction

  function automatic void heap_remove(int i);
    int ls;
    ls = m_cnt - 1;
    if (i != ls) begin
      m_dl[i] = m_dl[ls]; m_per[i] = m_per[ls];
      m_id[i] = m_id[ls]; m_single[i] = m_single[ls];
    end
    m_cnt = ls;
    if (i < m_cnt) begin
      heap_up(i);
      heap_down(i);
    end
  endfunction

  function automatic void push_beat(stat_e st, logic [31:0] id, logic lst);
    beat_t b;
    b.status = st; b.fired_id = id; b.fire_time = m_clock;
    b.active_count = m_cnt[5:0]; b.last = lst;
    pending_beats.push_back(b);
  endfunction

  // expected beats for one accepted item
  function automatic void timer_predict(func_e fn, logic [23:0] dly, logic [31:0] id);
    int n;
    bit hit;
    logic [31:0] fid; logic [23:0] per; logic s;
    case (fn)
      FN_ARM_PER, FN_ARM_ONE: begin
        if (m_cnt >= MAX_TIMERS) push_beat(ST_FULL, 0, 1);
        else begin
          heap_insert({8'd0, dly}, id, fn == FN_ARM_ONE);
          push_beat(ST_OK, 0, 1);
        end
      end
      FN_CANCEL: begin
        hit = 0;
        for (int i = 0; i < m_cnt; i++) begin
          if (!hit && m_id[i] == id) begin
            heap_remove(i);
            hit = 1;
          end
        end
        push_beat(hit ? ST_OK : ST_NOTFOUND, 0, 1);
      end
      default: begin
        m_clock++;
        n = 0;
        while (n < MAX_RESULTS && m_cnt > 0 && m_dl[0] <= m_clock) begin
          fid = m_id[0]; per = m_per[0]; s = m_single[0];
          heap_remove(0);
          if (!s) heap_insert(per == 0 ? 32'd1 : {8'd0, per}, fid, 0);
          push_beat(ST_FIRED, fid, 0);
          n++;
        end
        if (n == 0) push_beat(ST_NONE, 0, 1);
        else pending_beats[$].last = 1;
      end
    endcase
  endfunction

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // output checker; samples at rising edge
  always @(posedge clk_i) begin
    beat_t got, exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, fired_id_o, fire_time_o, active_count_o, last_o};
      if (pending_beats.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected beat: %p", got);
      end else begin
        exp_b = pending_beats.pop_front();
        if (got !== exp_b) begin
          errors++;
          if (mism++ < 10) $display("mismatch: exp %p got %p", exp_b, got);
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int k;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        k = $urandom_range(1, 11);
        repeat (k - 1) @(negedge clk_i);
      end else out_ready_i <= 1;
    end
  end

  // valid stays up after a beat until the next one is driven or the sender idles
  task automatic send_item(func_e fn, logic [23:0] dly, logic [31:0] id);
    int k;
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      k = $urandom_range(1, 11);
      repeat (k) @(negedge clk_i);
    end
    in_valid_i <= 1; func_i <= fn; delay_ms_i <= dly; timer_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
    timer_predict(fn, dly, id);
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    in_valid_i <= 0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  typedef struct {
    func_e       fn;
    logic [23:0] dly;
    logic [31:0] id;
    bit          chk;
    stat_e       st;
  } row_t;

  row_t dir_rows[$];
  logic [31:0] used_ids[$];

  initial begin
    int pick;
    logic [31:0] id;
    func_e fn;
    in_valid_i = 0; func_i = FN_TICK; delay_ms_i = 0; timer_id_i = 0;
    rst_ni = 0;
    m_cnt = 0; m_clock = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;

    // directed table; st is checked only where chk is set
    dir_rows = '{
      '{FN_TICK,    24'd0,        32'd0,          1, ST_NONE},
      '{FN_CANCEL,  24'd0,        32'hFFFF_FFFF,  1, ST_NOTFOUND},
      '{FN_ARM_PER, 24'd0,        32'hFFFF_FFFF,  1, ST_OK},
      '{FN_ARM_ONE, 24'hFF_FFFF,  32'd0,          1, ST_OK},
      '{FN_ARM_ONE, 24'd1,        32'h5555_AAAA,  1, ST_OK},
      '{FN_ARM_PER, 24'd2,        32'h5555_AAAA,  1, ST_OK},
      '{FN_TICK,    24'd0,        32'd0,          0, ST_NONE},
      '{FN_TICK,    24'd0,        32'd0,          0, ST_NONE},
      '{FN_CANCEL,  24'd0,        32'h5555_AAAA,  1, ST_OK},
      '{FN_CANCEL,  24'd0,        32'h5555_AAAA,  0, ST_OK},
      '{FN_TICK,    24'hFF_FFFF,  32'hFFFF_FFFF,  0, ST_NONE},
      '{FN_CANCEL,  24'd0,        32'd0,          1, ST_OK},
      '{FN_CANCEL,  24'd0,        32'hFFFF_FFFF,  1, ST_OK},
      '{FN_CANCEL,  24'd0,        32'hFFFF_FFFF,  1, ST_NOTFOUND}
    };
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].fn, dir_rows[i].dly, dir_rows[i].id);
      if (dir_rows[i].chk && pending_beats[$].status !== dir_rows[i].st) begin
        errors++;
        if (mism++ < 10)
          $display("table row %0d: exp status %0d got %0d", i, dir_rows[i].st,
                   pending_beats[$].status);
      end
    end
    // fill to full, arms while full, then ticks with many due at once
    for (int i = 0; i < MAX_TIMERS; i++) send_item(FN_ARM_PER, 24'd3, i);
    send_item(FN_ARM_ONE, 24'd1, 32'd99);
    send_item(FN_ARM_PER, 24'd1, 32'd98);
    repeat (5) send_item(FN_TICK, 24'd0, 32'd0);
    drain_all();  // sender waits for every result
    for (int i = 0; i < MAX_TIMERS; i++) send_item(FN_CANCEL, 24'd0, i);

    // random: mostly short delays and reused ids so timers fire and cancels hit
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 60) idle_off = 1;
      pick = $urandom_range(0, 9);
      if (pick < 4) fn = FN_TICK;
      else if (pick < 6) fn = FN_ARM_PER;
      else if (pick < 8) fn = FN_ARM_ONE;
      else fn = FN_CANCEL;
      if (fn == FN_CANCEL && used_ids.size() > 0 && $urandom_range(0, 3) != 0)
        id = used_ids[$urandom_range(0, used_ids.size() - 1)];
      else if ($urandom_range(0, 1)) id = $urandom_range(0, 15);
      else id = $urandom;
      if (fn != FN_CANCEL && fn != FN_TICK) used_ids.push_back(id);
      if (used_ids.size() > 40) void'(used_ids.pop_front());
      send_item(fn, ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12)),
                id);
    end
    drain_all();
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
